// ----- src/cartridge_header_check_defines.svh -----
// ----------------------------------------------------------------------------
// Cartridge header check: assertion macros
// Shared concurrent assertion forms, clocked on aclk, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_HEADER_CHECK_DEFINES_SVH
`define CARTRIDGE_HEADER_CHECK_DEFINES_SVH

// Same-cycle implication
`define CHC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cartridge header check: same-cycle assertion failed");

// Next-cycle implication
`define CHC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cartridge header check: next-cycle assertion failed");

`endif

// ----- src/chc_pkg.sv -----
// ----------------------------------------------------------------------------
// Cartridge header check package
// Header offsets, logo bytes, mapper codes and the shared header state type.
// ----------------------------------------------------------------------------
package chc_pkg;

    localparam int LOGO_BYTES = 48;

    localparam logic [8:0] OFS_LOGO_FIRST = 9'h104;
    localparam logic [8:0] OFS_LOGO_LAST  = 9'(OFS_LOGO_FIRST + LOGO_BYTES - 1);
    localparam logic [8:0] OFS_SUM_FIRST  = 9'h134;
    localparam logic [8:0] OFS_SUM_LAST   = 9'h14C;
    localparam logic [8:0] OFS_CHECK      = 9'h14D;
    localparam logic [8:0] OFS_CART_TYPE  = 9'h147;
    localparam logic [8:0] OFS_ROM_SIZE   = 9'h148;
    localparam logic [8:0] OFS_RAM_SIZE   = 9'h149;

    localparam logic [2:0] KIND_NROM    = 3'd0;
    localparam logic [2:0] KIND_MBC1    = 3'd1;
    localparam logic [2:0] KIND_MBC2    = 3'd2;
    localparam logic [2:0] KIND_MMM01   = 3'd3;
    localparam logic [2:0] KIND_MBC3    = 3'd4;
    localparam logic [2:0] KIND_MBC5    = 3'd5;
    localparam logic [2:0] KIND_UNKNOWN = 3'd6;

    localparam logic [7:0] LOGO_TABLE [LOGO_BYTES] = '{
        8'hCE, 8'hED, 8'h66, 8'h66, 8'hCC, 8'h0D, 8'h00, 8'h0B,
        8'h03, 8'h73, 8'h00, 8'h83, 8'h00, 8'h0C, 8'h00, 8'h0D,
        8'h00, 8'h08, 8'h11, 8'h1F, 8'h88, 8'h89, 8'h00, 8'h0E,
        8'hDC, 8'hCC, 8'h6E, 8'hE6, 8'hDD, 8'hDD, 8'hD9, 8'h99,
        8'hBB, 8'hBB, 8'h67, 8'h63, 8'h6E, 8'h0E, 8'hEC, 8'hCC,
        8'hDD, 8'hDC, 8'h99, 8'h9F, 8'hBB, 8'hB9, 8'h33, 8'h3E
    };

    // Header state carried from the tracker to the result stage
    typedef struct packed {
        logic       logo_match;
        logic [7:0] running_sum;
        logic [7:0] cart_type_code;
        logic [7:0] rom_size_code;
        logic [7:0] ram_size_code;
    } hdr_state_t;

endpackage

// ----- src/chc_track.sv -----
// ----------------------------------------------------------------------------
// Cartridge header tracker
// Compares logo bytes, runs the header checksum and latches the size codes.
// ----------------------------------------------------------------------------
module chc_track import chc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [8:0] byte_offset,
    input  logic [7:0] data_byte,
    output hdr_state_t hdr
);

`include "cartridge_header_check_defines.svh"

    logic       logo_match_reg, logo_match_next;
    logic [7:0] running_sum_reg, running_sum_next;
    logic [7:0] cart_type_reg, cart_type_next;
    logic [7:0] rom_size_reg, rom_size_next;
    logic [7:0] ram_size_reg, ram_size_next;

    logic       in_logo;
    logic       in_sum;
    logic [5:0] logo_idx;
    logic       logo_eq;
    logic [7:0] sum_base;
    logic [8:0] logo_ofs;

    // Decode the offset windows
    assign in_logo  = (byte_offset >= OFS_LOGO_FIRST) && (byte_offset <= OFS_LOGO_LAST);
    assign in_sum   = (byte_offset >= OFS_SUM_FIRST) && (byte_offset <= OFS_SUM_LAST);
    assign logo_ofs = byte_offset - OFS_LOGO_FIRST;
    assign logo_idx = logo_ofs[5:0];
    assign logo_eq  = in_logo && (data_byte == LOGO_TABLE[logo_idx]);
    assign sum_base = (byte_offset == OFS_SUM_FIRST) ? 8'h00 : running_sum_reg;

    // Update state for the current request
    always_comb begin
        logo_match_next  = logo_match_reg;
        running_sum_next = running_sum_reg;
        cart_type_next   = cart_type_reg;
        rom_size_next    = rom_size_reg;
        ram_size_next    = ram_size_reg;
        if (step && in_logo) begin
            logo_match_next = (byte_offset == OFS_LOGO_FIRST) ? logo_eq
                                                               : (logo_match_reg && logo_eq);
        end
        if (step && in_sum) begin
            running_sum_next = sum_base - data_byte - 8'd1;
            if (byte_offset == OFS_CART_TYPE) cart_type_next = data_byte;
            if (byte_offset == OFS_ROM_SIZE)  rom_size_next  = data_byte;
            if (byte_offset == OFS_RAM_SIZE)  ram_size_next  = data_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            logo_match_reg  <= 1'b1;
            running_sum_reg <= 8'h00;
            cart_type_reg   <= 8'h00;
            rom_size_reg    <= 8'h00;
            ram_size_reg    <= 8'h00;
        end else begin
            logo_match_reg  <= logo_match_next;
            running_sum_reg <= running_sum_next;
            cart_type_reg   <= cart_type_next;
            rom_size_reg    <= rom_size_next;
            ram_size_reg    <= ram_size_next;
        end
    end

    assign hdr = '{logo_match:     logo_match_reg,
                   running_sum:    running_sum_reg,
                   cart_type_code: cart_type_reg,
                   rom_size_code:  rom_size_reg,
                   ram_size_code:  ram_size_reg};

    // Checksum restarts from zero at its first byte
    `CHC_ASSERT_NEXT(a_sum_restart, step && byte_offset == OFS_SUM_FIRST,
        running_sum_reg == ~$past(data_byte))
    // A matching first logo byte rearms the logo match
    `CHC_ASSERT_NEXT(a_logo_rearm,
        step && byte_offset == OFS_LOGO_FIRST && data_byte == LOGO_TABLE[0],
        logo_match_reg)
    // Bytes outside the header leave the checksum alone
    `CHC_ASSERT_NEXT(a_sum_hold, !(step && in_sum), $stable(running_sum_reg))

endmodule

// ----- src/chc_result.sv -----
// ----------------------------------------------------------------------------
// Cartridge header result stage
// Decodes the latched codes and holds the verdict in the output register.
// ----------------------------------------------------------------------------
module chc_result import chc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  logic [7:0]  check_byte,
    input  hdr_state_t  hdr,
    input  logic        m_ready,
    output logic        m_valid,
    output logic        m_header_ok,
    output logic [2:0]  m_mapper_kind,
    output logic        m_battery_backed,
    output logic        m_has_clock,
    output logic [9:0]  m_rom_bank_count,
    output logic [4:0]  m_ram_bank_count,
    output logic [17:0] m_ram_size_bytes
);

    logic        valid_reg, valid_next;
    logic        ok_reg;
    logic [2:0]  kind_reg;
    logic        batt_reg;
    logic        clk_reg;
    logic [9:0]  rom_reg;
    logic [4:0]  ramb_reg;
    logic [17:0] ramsz_reg;

    logic        ok_c;
    logic [2:0]  kind_c;
    logic        batt_c;
    logic        clk_c;
    logic [9:0]  rom_c;
    logic [4:0]  ramb_c;
    logic [17:0] ramsz_c;

    // Decode the cart type
    always_comb begin
        batt_c = 1'b0;
        clk_c  = 1'b0;
        case (hdr.cart_type_code)
            8'h09:               begin batt_c = 1'b1; kind_c = KIND_NROM; end
            8'h00, 8'h08:        kind_c = KIND_NROM;
            8'h03:               begin batt_c = 1'b1; kind_c = KIND_MBC1; end
            8'h01, 8'h02:        kind_c = KIND_MBC1;
            8'h06:               begin batt_c = 1'b1; kind_c = KIND_MBC2; end
            8'h05:               kind_c = KIND_MBC2;
            8'h0D:               begin batt_c = 1'b1; kind_c = KIND_MMM01; end
            8'h0B, 8'h0C:        kind_c = KIND_MMM01;
            8'h0F, 8'h10: begin
                clk_c  = 1'b1;
                batt_c = 1'b1;
                kind_c = KIND_MBC3;
            end
            8'h13:               begin batt_c = 1'b1; kind_c = KIND_MBC3; end
            8'h11, 8'h12:        kind_c = KIND_MBC3;
            8'h1B, 8'h1E:        begin batt_c = 1'b1; kind_c = KIND_MBC5; end
            8'h19, 8'h1A, 8'h1C, 8'h1D: kind_c = KIND_MBC5;
            default:             kind_c = KIND_UNKNOWN;
        endcase
    end

    // Decode the ROM size code
    always_comb begin
        if (hdr.rom_size_code <= 8'd8) begin
            rom_c = 10'd2 << hdr.rom_size_code[3:0];
        end else begin
            case (hdr.rom_size_code)
                8'h52:   rom_c = 10'd72;
                8'h53:   rom_c = 10'd80;
                8'h54:   rom_c = 10'd96;
                default: rom_c = 10'd0;
            endcase
        end
    end

    // Decode the RAM size code
    always_comb begin
        case (hdr.ram_size_code)
            8'h01:   ramb_c = 5'd1;
            8'h02:   ramb_c = 5'd1;
            8'h03:   ramb_c = 5'd4;
            8'h04:   ramb_c = 5'd16;
            8'h05:   ramb_c = 5'd8;
            default: ramb_c = 5'd0;
        endcase
    end

    assign ramsz_c = (kind_c == KIND_MBC2) ? 18'd512 : {ramb_c, 13'd0};
    assign ok_c    = hdr.logo_match && (check_byte == hdr.running_sum);

    // Hold the result until taken, load a new one on a check request
    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ok_reg    <= ok_c;
            kind_reg  <= kind_c;
            batt_reg  <= batt_c;
            clk_reg   <= clk_c;
            rom_reg   <= rom_c;
            ramb_reg  <= ramb_c;
            ramsz_reg <= ramsz_c;
        end
    end

    assign m_valid          = valid_reg;
    assign m_header_ok      = ok_reg;
    assign m_mapper_kind    = kind_reg;
    assign m_battery_backed = batt_reg;
    assign m_has_clock      = clk_reg;
    assign m_rom_bank_count = rom_reg;
    assign m_ram_bank_count = ramb_reg;
    assign m_ram_size_bytes = ramsz_reg;

endmodule

// ----- src/cartridge_header_check.sv -----
// Cartridge header check. Takes one header byte per cycle with its offset and
// gives one result, the verdict and the decoded cartridge properties, when the
// byte at offset 0x14D arrives; every other offset gives no result. Each byte
// passes an input register, then the logo compare, checksum update and field
// decode between that register and the output register, so a new byte is taken
// in every cycle but for the only stall: a check byte that meets a result still
// waiting in the output register.
// ----------------------------------------------------------------------------
// Cartridge header check top level
// Input register, handshake control, header tracker and result stage.
// ----------------------------------------------------------------------------
module cartridge_header_check import chc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [8:0]  s_byte_offset,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_header_ok,
    output logic [2:0]  m_mapper_kind,
    output logic        m_battery_backed,
    output logic        m_has_clock,
    output logic [9:0]  m_rom_bank_count,
    output logic [4:0]  m_ram_bank_count,
    output logic [17:0] m_ram_size_bytes
);

`include "cartridge_header_check_defines.svh"

    logic       in_valid_reg, in_valid_next;
    logic [8:0] in_ofs_reg;
    logic [7:0] in_byte_reg;

    logic       is_check;
    logic       out_free;
    logic       advance;
    logic       take;
    hdr_state_t hdr;

    // Advance the held request unless a check byte finds the result slot full
    assign is_check = (in_ofs_reg == OFS_CHECK);
    assign out_free = !m_valid || m_ready;
    assign advance  = in_valid_reg && (!is_check || out_free);
    assign s_ready  = !in_valid_reg || advance;
    assign take     = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            in_ofs_reg  <= s_byte_offset;
            in_byte_reg <= s_data_byte;
        end
    end

    chc_track u_track (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .byte_offset (in_ofs_reg),
        .data_byte   (in_byte_reg),
        .hdr         (hdr)
    );

    chc_result u_result (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .load             (advance && is_check),
        .check_byte       (in_byte_reg),
        .hdr              (hdr),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_header_ok      (m_header_ok),
        .m_mapper_kind    (m_mapper_kind),
        .m_battery_backed (m_battery_backed),
        .m_has_clock      (m_has_clock),
        .m_rom_bank_count (m_rom_bank_count),
        .m_ram_bank_count (m_ram_bank_count),
        .m_ram_size_bytes (m_ram_size_bytes)
    );

    // A check request that moves on always shows a result next cycle
    `CHC_ASSERT_NEXT(a_check_loads, advance && is_check, m_valid)
    // A stalled check request stays in the input register unchanged
    `CHC_ASSERT_NEXT(a_check_holds, in_valid_reg && is_check && !out_free,
        in_valid_reg && $stable(in_ofs_reg) && $stable(in_byte_reg))
    // Non-check requests never stall
    `CHC_ASSERT_NOW(a_no_stall, in_valid_reg && !is_check, s_ready)

endmodule
